@@ hdl/lzw_rle90_decoder_unit_assert.svh @@
// Assertion macros used by the checker file of the decoder.
`ifndef LZW_RLE90_DECODER_UNIT_ASSERT_SVH
`define LZW_RLE90_DECODER_UNIT_ASSERT_SVH

// Implication in the same cycle.
`define LRD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decoder assertion failed");

// Implication into the next cycle.
`define LRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decoder assertion failed");

`endif

@@ hdl/lrd_pkg.sv @@
// ----------------------------------------------------------------------------
// lrd_pkg
// Types and constants shared by the decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrd_pkg;

  localparam logic [2:0] ST_DATA     = 3'd0;
  localparam logic [2:0] ST_NEED     = 3'd1;
  localparam logic [2:0] ST_ACCEPTED = 3'd2;
  localparam logic [2:0] ST_REFUSED  = 3'd3;
  localparam logic [2:0] ST_STARTED  = 3'd4;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_PULL  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [7:0] ESC_SYM    = 8'h90;
  localparam int         CODE_W     = 12;
  localparam logic [3:0] INIT_WIDTH = 4'd9;
  localparam logic [11:0] FIRST_FREE = 12'h100;

  typedef enum logic [3:0] {
    S_IDLE, S_PULL, S_SYM, S_WADDR, S_WDATA, S_LPOP, S_POP, S_GOT, S_EMIT
  } state_t;

  typedef struct packed {
    logic       do_push;
    logic       do_start;
    logic       load_res;
    logic [2:0] res_code;
    logic       rep_take;
    logic       esc_clr;
    logic       esc_set;
    logic       sym_begin;
    logic       walk_latch;
    logic       walk_data;
    logic       pop_issue;
    logic       sym_load_pop;
    logic       sym_zero;
    logic       rle_resolve;
    logic       rle_literal;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic bits_over16;
    logic sym_ready;
    logic depth_nz;
    logic rep_nz;
    logic esc;
    logic walk_oor;
    logic leaf;
    logic sym_is_esc;
    logic slot_free;
  } sts_t;

endpackage

@@ hdl/lrd_ram.sv @@
// ----------------------------------------------------------------------------
// lrd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/lrd_ctrl.sv @@
// ----------------------------------------------------------------------------
// lrd_ctrl
// Sequencer for transactions, code expansion and the run-length layer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [1:0]    in_op,
  output logic          in_ready,
  input  lrd_pkg::sts_t sts,
  output lrd_pkg::cmd_t cmd
);

  lrd_pkg::state_t state, state_next;
  logic phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrd_pkg::S_IDLE;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    case (state)
      lrd_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = (in_op == lrd_pkg::OP_PULL) ? lrd_pkg::S_PULL : lrd_pkg::S_EMIT;
        end
      end
      lrd_pkg::S_PULL: begin
        if (sts.rep_nz || !sts.sym_ready) begin
          state_next = lrd_pkg::S_EMIT;
        end else begin
          phase_next = sts.esc;
          state_next = lrd_pkg::S_SYM;
        end
      end
      lrd_pkg::S_SYM: begin
        state_next = sts.depth_nz ? lrd_pkg::S_POP : lrd_pkg::S_WADDR;
      end
      lrd_pkg::S_WADDR: begin
        state_next = sts.walk_oor ? lrd_pkg::S_GOT : lrd_pkg::S_WDATA;
      end
      lrd_pkg::S_WDATA: begin
        state_next = sts.leaf ? lrd_pkg::S_LPOP : lrd_pkg::S_WADDR;
      end
      lrd_pkg::S_LPOP: begin
        state_next = sts.depth_nz ? lrd_pkg::S_POP : lrd_pkg::S_GOT;
      end
      lrd_pkg::S_POP: begin
        state_next = lrd_pkg::S_GOT;
      end
      lrd_pkg::S_GOT: begin
        if (!phase && sts.sym_is_esc && sts.sym_ready) begin
          phase_next = 1'b1;
          state_next = lrd_pkg::S_SYM;
        end else begin
          state_next = lrd_pkg::S_EMIT;
        end
      end
      lrd_pkg::S_EMIT: begin
        if (sts.slot_free) begin
          state_next = lrd_pkg::S_IDLE;
        end
      end
      default: state_next = lrd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      lrd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_op)
            lrd_pkg::OP_PUSH: begin
              cmd.load_res = 1'b1;
              if (sts.bits_over16) begin
                cmd.res_code = lrd_pkg::ST_REFUSED;
              end else begin
                cmd.do_push  = 1'b1;
                cmd.res_code = lrd_pkg::ST_ACCEPTED;
              end
            end
            lrd_pkg::OP_START: begin
              cmd.do_start = 1'b1;
              cmd.load_res = 1'b1;
              cmd.res_code = lrd_pkg::ST_STARTED;
            end
            lrd_pkg::OP_PULL: ;
            default: begin
              cmd.load_res = 1'b1;
              cmd.res_code = lrd_pkg::ST_REFUSED;
            end
          endcase
        end
      end
      lrd_pkg::S_PULL: begin
        if (sts.rep_nz) begin
          cmd.rep_take = 1'b1;
        end else if (!sts.sym_ready) begin
          cmd.load_res = 1'b1;
          cmd.res_code = lrd_pkg::ST_NEED;
        end else begin
          cmd.esc_clr = sts.esc;
        end
      end
      lrd_pkg::S_SYM: begin
        if (sts.depth_nz) begin
          cmd.pop_issue = 1'b1;
        end else begin
          cmd.sym_begin = 1'b1;
        end
      end
      lrd_pkg::S_WADDR: begin
        if (sts.walk_oor) begin
          cmd.sym_zero = 1'b1;
        end else begin
          cmd.walk_latch = 1'b1;
        end
      end
      lrd_pkg::S_WDATA: cmd.walk_data = 1'b1;
      lrd_pkg::S_LPOP: begin
        if (sts.depth_nz) begin
          cmd.pop_issue = 1'b1;
        end else begin
          cmd.sym_zero = 1'b1;
        end
      end
      lrd_pkg::S_POP: cmd.sym_load_pop = 1'b1;
      lrd_pkg::S_GOT: begin
        if (phase) begin
          cmd.rle_resolve = 1'b1;
        end else if (sts.sym_is_esc) begin
          if (!sts.sym_ready) begin
            cmd.esc_set  = 1'b1;
            cmd.load_res = 1'b1;
            cmd.res_code = lrd_pkg::ST_NEED;
          end
        end else begin
          cmd.rle_literal = 1'b1;
        end
      end
      lrd_pkg::S_EMIT: cmd.emit = sts.slot_free;
      default: ;
    endcase
  end

endmodule

@@ hdl/lrd_datapath.sv @@
// ----------------------------------------------------------------------------
// lrd_datapath
// Bit accumulator, dictionary, character stack, run-length state and the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrd_datapath #(
  parameter int DICT_ENTRIES  = 2048,
  parameter int STACK_DEPTH   = 4096,
  parameter int MAX_WIDTH_CAP = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [15:0]   in_word,
  input  logic          nibble_mode,
  input  lrd_pkg::cmd_t cmd,
  output lrd_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_status,
  output logic [7:0]    out_data,
  output logic          out_last
);

  localparam int DAW = $clog2(DICT_ENTRIES);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SDW = $clog2(STACK_DEPTH + 1);
  localparam int CW  = lrd_pkg::CODE_W;

  logic [31:0]     acc;
  logic [5:0]      bits_held;
  logic [3:0]      code_width;
  logic [3:0]      width_limit;
  logic [CW-1:0]   next_free;
  logic [CW:0]     high_water;
  logic [CW-1:0]   prev_code;
  logic [CW-1:0]   cur_code;
  logic [CW-1:0]   walk;
  logic [7:0]      first_char;
  logic [7:0]      repeats_left;
  logic [7:0]      held_literal;
  logic            escape_pending;
  logic            leaf;
  logic [SDW-1:0]  depth;
  logic [7:0]      sym;
  logic [2:0]      res_status;
  logic [7:0]      res_byte;
  logic            hi_pend;
  logic [3:0]      hi_nib;

  logic            stk_we;
  logic [SAW-1:0]  stk_waddr;
  logic [7:0]      stk_wdata;
  logic [SAW-1:0]  stk_raddr;
  logic [7:0]      stk_rdata;
  logic            dict_we;
  logic [DAW-1:0]  dict_waddr;
  logic [CW-1:0]   pfx_rdata;
  logic [7:0]      sym_rdata;

  logic [CW:0]     mask;
  logic [CW-1:0]   code;
  logic [CW:0]     nc;
  logic [3:0]      width_up;
  logic            entry_valid;
  logic            stack_full;
  logic [7:0]      walk_sym;
  logic [7:0]      start_lim;
  logic [SDW-1:0]  depth_dec;
  logic            push_en;
  logic [7:0]      push_char;

  assign mask        = (CW+1)'((13'd1 << code_width) - 13'd1);
  assign code        = acc[CW-1:0] & mask[CW-1:0];
  assign nc          = {1'b0, next_free} + (CW+1)'(1);
  assign width_up    = (nc > mask) ? code_width + 4'd1 : code_width;
  assign entry_valid = (walk >= CW'(256)) && (walk < next_free);
  assign stack_full  = depth >= SDW'(STACK_DEPTH);
  assign depth_dec   = depth - SDW'(1);
  assign start_lim   = (in_word[7:0] > 8'(MAX_WIDTH_CAP)) ? 8'(MAX_WIDTH_CAP) : in_word[7:0];

  always_comb begin
    if (walk < CW'(256)) begin
      walk_sym = walk[7:0];
    end else if ({1'b0, walk} < high_water) begin
      walk_sym = sym_rdata;
    end else begin
      walk_sym = 8'h00;
    end
  end

  always_comb begin
    push_en   = 1'b0;
    push_char = walk_sym;
    if (cmd.sym_begin && (code >= next_free)) begin
      push_en   = 1'b1;
      push_char = first_char;
    end else if (cmd.walk_data) begin
      push_en = 1'b1;
    end
  end

  assign stk_we     = push_en && !stack_full;
  assign stk_waddr  = depth[SAW-1:0];
  assign stk_wdata  = push_char;
  assign stk_raddr  = depth_dec[SAW-1:0];
  assign dict_we    = cmd.walk_data && leaf && ({1'b0, next_free} < (CW+1)'(DICT_ENTRIES));
  assign dict_waddr = next_free[DAW-1:0];

  lrd_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  lrd_ram #(.WIDTH(CW), .DEPTH(DICT_ENTRIES)) u_prefix (
    .clk(clk), .we(dict_we), .waddr(dict_waddr), .wdata(prev_code),
    .raddr(walk[DAW-1:0]), .rdata(pfx_rdata)
  );

  lrd_ram #(.WIDTH(8), .DEPTH(DICT_ENTRIES)) u_symbol (
    .clk(clk), .we(dict_we), .waddr(dict_waddr), .wdata(walk_sym),
    .raddr(walk[DAW-1:0]), .rdata(sym_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      acc            <= '0;
      bits_held      <= '0;
      code_width     <= lrd_pkg::INIT_WIDTH;
      width_limit    <= 4'd11;
      next_free      <= lrd_pkg::FIRST_FREE;
      high_water     <= (CW+1)'(256);
      prev_code      <= '0;
      first_char     <= '0;
      repeats_left   <= '0;
      held_literal   <= '0;
      escape_pending <= 1'b0;
      depth          <= '0;
      out_valid      <= 1'b0;
      hi_pend        <= 1'b0;
    end else begin
      if (stk_we) begin
        depth <= depth + SDW'(1);
      end
      if (cmd.do_push) begin
        acc       <= acc | ({16'h0000, in_word} << bits_held);
        bits_held <= bits_held + 6'd16;
      end
      if (cmd.do_start) begin
        width_limit    <= start_lim[3:0];
        acc            <= {24'h000000, in_word[15:8]};
        bits_held      <= 6'd8;
        depth          <= '0;
        repeats_left   <= '0;
        held_literal   <= '0;
        escape_pending <= 1'b0;
        code_width     <= lrd_pkg::INIT_WIDTH;
        next_free      <= lrd_pkg::FIRST_FREE;
      end
      if (cmd.rep_take) begin
        repeats_left <= repeats_left - 8'd1;
      end
      if (cmd.esc_clr) begin
        escape_pending <= 1'b0;
      end
      if (cmd.esc_set) begin
        escape_pending <= 1'b1;
      end
      if (cmd.pop_issue) begin
        depth <= depth_dec;
      end
      if (cmd.sym_begin) begin
        acc       <= acc >> code_width;
        bits_held <= bits_held - {2'b00, code_width};
        if (code >= next_free) begin
          cur_code <= next_free;
          walk     <= prev_code;
        end else begin
          cur_code <= code;
          walk     <= code;
        end
      end
      if (cmd.walk_latch) begin
        leaf <= !entry_valid || stack_full;
      end
      if (cmd.walk_data) begin
        if (!leaf) begin
          walk <= pfx_rdata;
        end else begin
          first_char <= walk_sym;
          prev_code  <= cur_code;
          if (dict_we && (nc > high_water)) begin
            high_water <= nc;
          end
          if (width_up > width_limit) begin
            code_width <= lrd_pkg::INIT_WIDTH;
            next_free  <= lrd_pkg::FIRST_FREE;
          end else begin
            code_width <= width_up;
            next_free  <= nc[CW-1:0];
          end
        end
      end
      if (cmd.rle_resolve) begin
        if (sym == 8'h00) begin
          held_literal <= lrd_pkg::ESC_SYM;
        end else begin
          repeats_left <= sym - 8'd2;
        end
      end
      if (cmd.rle_literal) begin
        held_literal <= sym;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        hi_pend   <= nibble_mode && (res_status == lrd_pkg::ST_DATA);
      end else if (out_valid && out_ready) begin
        if (hi_pend) begin
          hi_pend <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sym_load_pop) begin
      sym <= stk_rdata;
    end
    if (cmd.sym_zero) begin
      sym <= 8'h00;
    end
    if (cmd.load_res) begin
      res_status <= cmd.res_code;
    end
    if (cmd.rep_take) begin
      res_status <= lrd_pkg::ST_DATA;
      res_byte   <= held_literal;
    end
    if (cmd.rle_resolve) begin
      res_status <= lrd_pkg::ST_DATA;
      res_byte   <= (sym == 8'h00) ? lrd_pkg::ESC_SYM : held_literal;
    end
    if (cmd.rle_literal) begin
      res_status <= lrd_pkg::ST_DATA;
      res_byte   <= sym;
    end
    if (out_valid && out_ready && hi_pend) begin
      out_data <= {4'h0, hi_nib};
      out_last <= 1'b1;
    end
    if (cmd.emit) begin
      out_status <= res_status;
      hi_nib     <= res_byte[7:4];
      if (res_status != lrd_pkg::ST_DATA) begin
        out_data <= 8'h00;
        out_last <= 1'b1;
      end else if (nibble_mode) begin
        out_data <= {4'h0, res_byte[3:0]};
        out_last <= 1'b0;
      end else begin
        out_data <= res_byte;
        out_last <= 1'b1;
      end
    end
  end

  assign sts.bits_over16 = bits_held > 6'd16;
  assign sts.sym_ready   = (depth != '0) || ({2'b00, code_width} <= bits_held);
  assign sts.depth_nz    = depth != '0;
  assign sts.rep_nz      = repeats_left != 8'h00;
  assign sts.esc         = escape_pending;
  assign sts.walk_oor    = {1'b0, walk} >= (CW+1)'(DICT_ENTRIES);
  assign sts.leaf        = leaf;
  assign sts.sym_is_esc  = sym == lrd_pkg::ESC_SYM;
  assign sts.slot_free   = !out_valid || (out_ready && !hi_pend);

endmodule

@@ hdl/lzw_rle90_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// lzw_rle90_decoder_unit
// Variable-width LZW decoder with a run-length expander on its output.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A push, start or refused operation
// loads its result while idle and then passes to the emit state. A pull
// served from a pending repeat goes through the pull and emit states, one
// served from the character stack also pops its symbol, and one that decodes
// a fresh code walks the prefix chain above the leaf, where each link is one
// read of the dictionary memory followed by one push onto the stack memory;
// an escape needs a second symbol and goes through the symbol states again.
// A stalled sink keeps the decoder in the emit state. The dictionary needs no
// clearing pass after reset or start. A nibble-mode byte leaves as two nibble
// results on consecutive cycles when the sink is ready.
`timescale 1ns / 1ps

module lzw_rle90_decoder_unit #(
  parameter int DICT_ENTRIES  = 2048,
  parameter int STACK_DEPTH   = 4096,
  parameter int MAX_WIDTH_CAP = 11
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // word
  input  logic [1:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // data
  output logic [2:0]  m_tuser,   // status
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lrd_pkg::cmd_t cmd;
  lrd_pkg::sts_t sts;
  logic          nibble_mode;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'h0, nibble_mode} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      nibble_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      nibble_mode <= pwdata[0];
    end
  end

  lrd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_op(s_tuser),
    .in_ready(s_tready), .sts(sts), .cmd(cmd)
  );

  lrd_datapath #(
    .DICT_ENTRIES(DICT_ENTRIES), .STACK_DEPTH(STACK_DEPTH),
    .MAX_WIDTH_CAP(MAX_WIDTH_CAP)
  ) u_dp (
    .clk(clk), .rst(rst), .in_word(s_tdata), .nibble_mode(nibble_mode),
    .cmd(cmd), .sts(sts), .out_valid(m_tvalid), .out_ready(m_tready),
    .out_status(m_tuser), .out_data(m_tdata), .out_last(m_tlast)
  );

endmodule

@@ hdl/lrd_checker.sv @@
// ----------------------------------------------------------------------------
// lrd_checker
// Port-level checks on the result stream of the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lzw_rle90_decoder_unit_assert.svh"

module lrd_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [2:0] m_tuser,
  input logic       m_tlast
);

  `LRD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
  `LRD_ASSERT_NOW(a_status_only, m_tvalid && (m_tuser != lrd_pkg::ST_DATA), m_tlast && (m_tdata == 8'h00))
  `LRD_ASSERT_NOW(a_first_nibble, m_tvalid && !m_tlast, (m_tuser == lrd_pkg::ST_DATA) && (m_tdata[7:4] == 4'h0))
  `LRD_ASSERT_NEXT(a_second_nibble, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tlast && (m_tuser == lrd_pkg::ST_DATA))

endmodule

bind lzw_rle90_decoder_unit lrd_checker u_lrd_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
